>>> design/ebgc_pkg.sv
package ebgc_pkg;

   localparam int unsigned POS_WIDTH  = 16;
   localparam int unsigned TIME_WIDTH = 32;
   localparam int unsigned CFG_WIDTH  = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [CFG_WIDTH-1:0] HOLD_THRESHOLD_RESET = 16'd800;
   localparam logic [CFG_WIDTH-1:0] DOUBLE_WINDOW_RESET  = 16'd300;

   // Action codes reported per request.
   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_CW     = 3'd1,
      ACT_CCW    = 3'd2,
      ACT_SINGLE = 3'd3,
      ACT_DOUBLE = 3'd4,
      ACT_HOLD   = 3'd5
   } action_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HOLD_THRESHOLD = 2'd0,
      CSR_DOUBLE_WINDOW  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] hold_threshold_ms;
      logic [CFG_WIDTH-1:0] double_click_window_ms;
   } cfg_type;

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] previous_position;
      logic                        button_was_down;
      logic [TIME_WIDTH-1:0]       press_start_time;
      logic                        hold_reported;
      logic [TIME_WIDTH-1:0]       pending_click_time;
   } state_type;

endpackage

>>> design/ebgc_csr.sv
module ebgc_csr
   import ebgc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Users write only while idle (not enforced); writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HOLD_THRESHOLD: cfg_in.hold_threshold_ms      = csr_wdata;
            CSR_DOUBLE_WINDOW:  cfg_in.double_click_window_ms = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_threshold_ms      <= HOLD_THRESHOLD_RESET;
         cfg_ff.double_click_window_ms <= DOUBLE_WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/ebgc_classify.sv
module ebgc_classify
   import ebgc_pkg::*;
(
   input  state_type                   state,
   input  cfg_type                     cfg,
   input  logic signed [POS_WIDTH-1:0] encoder_position,
   input  logic                        button_down,
   input  logic [TIME_WIDTH-1:0]       now_ms,
   output action_type                  action,
   output state_type                   state_next
);

   logic [TIME_WIDTH-1:0] hold_thr;
   logic [TIME_WIDTH-1:0] dbl_win;
   logic [TIME_WIDTH-1:0] press_len;
   logic [TIME_WIDTH-1:0] since_click;
   logic [TIME_WIDTH-1:0] since_click_new;
   logic [TIME_WIDTH-1:0] since_press_new;
   state_type             st;
   action_type            act;
   logic                  done;

   assign hold_thr = {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, cfg.hold_threshold_ms};
   assign dbl_win  = {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, cfg.double_click_window_ms};

   // Differences against the stored times, all wrapping modulo 2^32.
   assign press_len   = now_ms - state.press_start_time;
   assign since_click = now_ms - state.pending_click_time;

   always_comb begin
      st   = state;
      act  = ACT_NONE;
      done = 1'b0;
      since_click_new = '0;
      since_press_new = '0;
      if (encoder_position != state.previous_position) begin
         act  = (encoder_position > state.previous_position) ? ACT_CW : ACT_CCW;
         st.previous_position = encoder_position;
         done = 1'b1;
      end else begin
         if (button_down && !state.button_was_down) begin
            st.press_start_time = now_ms;
            st.button_was_down  = 1'b1;
            st.hold_reported    = 1'b0;
         end else if (!button_down && state.button_was_down) begin
            st.button_was_down = 1'b0;
            if (press_len < hold_thr) begin
               if (since_click < dbl_win) begin
                  st.pending_click_time = '0;
                  act  = ACT_DOUBLE;
                  done = 1'b1;
               end else begin
                  st.pending_click_time = now_ms;
               end
            end
         end
         since_click_new = now_ms - st.pending_click_time;
         since_press_new = now_ms - st.press_start_time;
         if (!done) begin
            if ((st.pending_click_time != '0) && (since_click_new > dbl_win) &&
                !button_down) begin
               st.pending_click_time = '0;
               act = ACT_SINGLE;
            end else if (button_down && !st.hold_reported &&
                         (since_press_new > hold_thr)) begin
               st.hold_reported = 1'b1;
               act = ACT_HOLD;
            end
         end
      end
   end

   assign action     = act;
   assign state_next = st;

endmodule

>>> design/encoder_button_gesture_classifier_core.sv
// An accepted request is classified from the input register and its result is offered from the result register.
// Throughput: one request per clock cycle, limited only by rsp_stall backpressure.
// One classification pass between the input register and the result register
// sets the rate; the gesture state is updated in the same cycle as the result.
// Reset (synchronous, active high) clears the gesture state, empties both
// pipeline registers and loads the thresholds with 800 ms and 300 ms.
module encoder_button_gesture_classifier_core
   import ebgc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [POS_WIDTH-1:0] req_encoder_position,
   input  logic                        req_button_down,
   input  logic [TIME_WIDTH-1:0]       req_now_ms,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_action,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CFG_WIDTH-1:0]        csr_wdata
);

   // Configuration registers.
   cfg_type cfg;

   ebgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register stage. A request sits here until the result register
   // can take its classification.
   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic signed [POS_WIDTH-1:0] in_pos_ff;
   logic                        in_down_ff;
   logic [TIME_WIDTH-1:0]       in_now_ms_ff;

   logic       out_valid_ff;
   logic       out_valid_in;
   action_type out_action_ff;

   state_type  state_ff;
   state_type  state_in;
   state_type  state_next;
   action_type action;

   logic advance;
   logic req_take;

   // The input stage moves forward when the result register is empty or is
   // being emptied this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   ebgc_classify u_classify (
      .state            (state_ff),
      .cfg              (cfg),
      .encoder_position (in_pos_ff),
      .button_down      (in_down_ff),
      .now_ms           (in_now_ms_ff),
      .action           (action),
      .state_next       (state_next)
   );

   // The gesture state only changes when a request is actually classified,
   // so a stalled request is never counted twice.
   assign state_in = advance ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pos_ff    <= req_encoder_position;
         in_down_ff   <= req_button_down;
         in_now_ms_ff <= req_now_ms;
      end
      if (advance) begin
         out_action_ff <= action;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_action = out_action_ff;

   // The gesture state holds whenever no request is being classified.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("gesture state changed without a classified request");

   // A reported hold marks the current press as already reported.
   a_hold_marked: assert property (@(posedge clock) disable iff (reset)
      advance && (action == ACT_HOLD) |=> state_ff.hold_reported)
      else $error("hold reported but not recorded");

   // A rotation records the new encoder count.
   a_rotation_tracked: assert property (@(posedge clock) disable iff (reset)
      advance && ((action == ACT_CW) || (action == ACT_CCW))
      |=> state_ff.previous_position == $past(in_pos_ff))
      else $error("rotation did not update previous position");

   // A classified request always lands in the result register.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("classified request lost");

   // Backpressure on the input only comes from a full, stalled result register.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without downstream backpressure");

endmodule

>>> test/tb_encoder_button_gesture_classifier_core.sv
import ebgc_pkg::*;

// Keeps a private copy of the gesture state and the two thresholds, predicts the
// action for every accepted request and compares it with what the block reports.
class gesture_actions;
   logic [CFG_WIDTH-1:0]        hold_limit = HOLD_THRESHOLD_RESET;
   logic [CFG_WIDTH-1:0]        dbl_window = DOUBLE_WINDOW_RESET;
   logic signed [POS_WIDTH-1:0] last_pos   = '0;
   bit                          btn_held   = 1'b0;
   logic [TIME_WIDTH-1:0]       press_t    = '0;
   bit                          hold_done  = 1'b0;
   logic [TIME_WIDTH-1:0]       click_t    = '0;
   action_type                  expected_actions[$];
   int unsigned                 failures   = 0;

   function void write_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
      if (idx == CSR_HOLD_THRESHOLD)
         hold_limit = value;
      else if (idx == CSR_DOUBLE_WINDOW)
         dbl_window = value;
   endfunction

   function action_type predict_action(logic signed [POS_WIDTH-1:0] pos, logic down,
                                       logic [TIME_WIDTH-1:0] now);
      logic [TIME_WIDTH-1:0] held_ms;
      logic [TIME_WIDTH-1:0] since_click;
      action_type            turn;
      if (pos != last_pos) begin
         turn = (pos > last_pos) ? ACT_CW : ACT_CCW;
         last_pos = pos;
         return turn;
      end
      if (down && !btn_held) begin
         press_t   = now;
         btn_held  = 1'b1;
         hold_done = 1'b0;
      end else if (!down && btn_held) begin
         held_ms  = now - press_t;
         btn_held = 1'b0;
         if (held_ms < {16'd0, hold_limit}) begin
            since_click = now - click_t;
            if (since_click < {16'd0, dbl_window}) begin
               click_t = '0;
               return ACT_DOUBLE;
            end
            click_t = now;
         end
      end
      since_click = now - click_t;
      if (click_t != 0 && since_click > {16'd0, dbl_window} && !down) begin
         click_t = '0;
         return ACT_SINGLE;
      end
      held_ms = now - press_t;
      if (down && !hold_done && held_ms > {16'd0, hold_limit}) begin
         hold_done = 1'b1;
         return ACT_HOLD;
      end
      return ACT_NONE;
   endfunction

   function void note_poll(logic signed [POS_WIDTH-1:0] pos, logic down,
                           logic [TIME_WIDTH-1:0] now);
      expected_actions.push_back(predict_action(pos, down, now));
   endfunction

   function void check_action(logic [2:0] got);
      action_type want;
      if (expected_actions.size() == 0) begin
         $error("action %0d arrived with no request outstanding", got);
         failures++;
         return;
      end
      want = expected_actions.pop_front();
      if (got !== want) begin
         $error("action mismatch: expected %s (%0d), actual %0d", want.name(), want, got);
         failures++;
      end
   endfunction

   function int unsigned outstanding();
      return expected_actions.size();
   endfunction
endclass

module tb_encoder_button_gesture_classifier_core;

   // Indexes past the two real registers; the block must ignore writes to them.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 2'd3;

   // The receiver's long hold-off must stay well below the watchdog limit.
   localparam int unsigned HOLDOFF_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [POS_WIDTH-1:0] req_encoder_position = '0;
   logic                        req_button_down = 1'b0;
   logic [TIME_WIDTH-1:0]       req_now_ms = '0;

   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [2:0]                  rsp_action;

   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [CFG_WIDTH-1:0]        csr_wdata = '0;

   gesture_actions action_board = new;

   // Stimulus bookkeeping. The dial is the encoder count the next request carries
   // unless a rotation changes it; clock_ms is the millisecond timestamp.
   logic signed [POS_WIDTH-1:0] dial = '0;
   logic [TIME_WIDTH-1:0]       clock_ms = '0;
   int unsigned                 cur_hold = 32'(HOLD_THRESHOLD_RESET);
   int unsigned                 cur_window = 32'(DOUBLE_WINDOW_RESET);
   int unsigned                 polls_sent = 0;

   // When set, the sender or the receiver stops idling between requests.
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   // A one-shot flag that starts the receiver's long hold-off stall, loaded from HOLDOFF_CYCLES.
   bit rsp_hold_request = 1'b0;

   encoder_button_gesture_classifier_core uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_encoder_position (req_encoder_position),
      .req_button_down      (req_button_down),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_action           (rsp_action),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   // Offers one request after a random gap and returns at the clock edge where it
   // is accepted. The valid line stays high when the next request follows without
   // a gap, so it is never lowered and raised again within one time step.
   task automatic send_poll(input logic signed [POS_WIDTH-1:0] pos, input logic down,
                            input logic [TIME_WIDTH-1:0] now);
      int unsigned gap;
      gap = req_burst ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_encoder_position <= pos;
      req_button_down      <= down;
      req_now_ms           <= now;
      do @(posedge clock); while (req_stall);
      action_board.note_poll(pos, down, now);
      polls_sent++;
   endtask

   task automatic step_poll(input logic down, input int unsigned delta_ms);
      clock_ms = clock_ms + delta_ms;
      send_poll(dial, down, clock_ms);
   endtask

   // Stops offering requests and waits until every predicted action has come back.
   task automatic drain_actions();
      req_valid <= 1'b0;
      while (action_board.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CFG_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      action_board.write_register(idx, value);
   endtask

   // Time step between polls, scaled to the current thresholds so that clicks,
   // windows and holds all land on both sides of their limits.
   function automatic int unsigned pace_ms();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return $urandom_range(0, cur_window + 2);
         2: return $urandom_range(0, cur_hold + 2);
         default: return $urandom_range(0, 2 * (cur_hold + cur_window) + 10);
      endcase
   endfunction

   // A press followed by a release shorter than max_dur milliseconds, with up to two
   // polls in between while the button is held.
   task automatic play_click(input int unsigned press_gap, input int unsigned max_dur);
      int unsigned dur, elapsed, d, steps;
      dur = (max_dur == 0) ? 0 : $urandom_range(0, max_dur - 1);
      elapsed = 0;
      step_poll(1'b1, press_gap);
      steps = $urandom_range(0, 2);
      repeat (steps) begin
         d = $urandom_range(0, dur / 3);
         elapsed += d;
         step_poll(1'b1, d);
      end
      step_poll(1'b0, dur - elapsed);
   endtask

   task automatic play_spin(input logic down);
      int unsigned turns;
      logic signed [POS_WIDTH-1:0] next_pos;
      turns = $urandom_range(1, 3);
      repeat (turns) begin
         case ($urandom_range(0, 7))
            0: next_pos = 16'sh7FFF;
            1: next_pos = 16'sh8000;
            2: next_pos = 16'($urandom_range(0, 65535));
            3, 4, 5: next_pos = dial + 16'($urandom_range(1, 3));
            default: next_pos = dial - 16'($urandom_range(1, 3));
         endcase
         if (next_pos == dial)
            next_pos = dial + 16'sd1;
         dial = next_pos;
         step_poll(down, $urandom_range(0, 3));
      end
   endtask

   // A press held past the threshold, sometimes with the knob turned meanwhile.
   task automatic play_hold();
      int unsigned held, steps, d;
      held = 0;
      step_poll(1'b1, pace_ms());
      steps = $urandom_range(1, 4);
      repeat (steps) begin
         if ($urandom_range(0, 3) == 0)
            play_spin(1'b1);
         d = $urandom_range(0, cur_hold / 2 + 2);
         held += d;
         step_poll(1'b1, d);
      end
      if (held <= cur_hold)
         step_poll(1'b1, cur_hold + 1 - held);
      step_poll(1'b0, $urandom_range(0, 3));
   endtask

   task automatic play_pause();
      int unsigned polls;
      polls = $urandom_range(1, 4);
      repeat (polls) step_poll(1'b0, pace_ms());
   endtask

   // Requests with unrelated fields: random counts, levels and timestamps.
   task automatic play_noise();
      int unsigned polls;
      polls = $urandom_range(1, 3);
      repeat (polls) begin
         if ($urandom_range(0, 1) == 0)
            dial = 16'($urandom_range(0, 65535));
         if ($urandom_range(0, 2) == 0)
            clock_ms = $urandom;
         else
            clock_ms = clock_ms + pace_ms();
         send_poll(dial, 1'($urandom_range(0, 1)), clock_ms);
      end
   endtask

   // Mostly well-formed gestures with random timing, and a tenth noise.
   task automatic run_gestures(input int unsigned count);
      int unsigned target;
      target = polls_sent + count;
      while (polls_sent < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               play_click(pace_ms(), cur_hold);
               play_pause();
            end
            3, 4: begin
               play_click(pace_ms(), cur_hold);
               play_click($urandom_range(0, cur_window / 2), cur_window / 2);
               play_pause();
            end
            5, 6: play_hold();
            7: play_spin(1'b0);
            8: play_pause();
            default: play_noise();
         endcase
      end
   endtask

   task automatic run_phase(input logic [CFG_WIDTH-1:0] hold, input logic [CFG_WIDTH-1:0] win,
                            input int unsigned count);
      drain_actions();
      write_register(CSR_HOLD_THRESHOLD, hold);
      write_register(CSR_DOUBLE_WINDOW, win);
      cur_hold   = 32'(hold);
      cur_window = 32'(win);
      run_gestures(count);
   endtask

   // The receiver draws a stall length after every accepted action. A hold-off
   // request overrides that with one long stall so that the block fills up.
   initial begin : action_sink
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            action_board.check_action(rsp_action);
            stall_left = rsp_burst ? 0 : $urandom_range(0, 14);
         end
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            stall_left = HOLDOFF_CYCLES;
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0)
            stall_left--;
      end
   end

   // Ends the run if no request, action or register write is accepted before the
   // quiet count reaches WATCHDOG_LIMIT.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests with the reset thresholds of 800 ms and 300 ms.
      send_poll(16'sd0, 1'b0, 32'd0);         // Nothing changes.
      send_poll(16'sh7FFF, 1'b0, 32'd10);     // Largest count: clockwise.
      send_poll(16'sh8000, 1'b0, 32'd20);     // Wrap to the smallest: counter-clockwise.
      // A short click while the timestamp is still inside the window counts as a
      // double click even though no earlier click is pending.
      send_poll(16'sh8000, 1'b1, 32'd100);
      send_poll(16'sh8000, 1'b0, 32'd150);
      // A lone click becomes a single click once the window has passed.
      send_poll(16'sh8000, 1'b1, 32'd1000);
      send_poll(16'sh8000, 1'b0, 32'd1100);
      send_poll(16'sh8000, 1'b0, 32'd1500);
      // Two clicks 150 ms apart make a real double click.
      send_poll(16'sh8000, 1'b1, 32'd2000);
      send_poll(16'sh8000, 1'b0, 32'd2100);
      send_poll(16'sh8000, 1'b1, 32'd2200);
      send_poll(16'sh8000, 1'b0, 32'd2250);
      // The knob turns during a press, so the button is not looked at in that
      // request; the hold is then reported once, and the long release is no click.
      send_poll(16'sh8000, 1'b1, 32'd3000);
      send_poll(16'sd5, 1'b1, 32'd3500);
      send_poll(16'sd5, 1'b1, 32'd3900);
      send_poll(16'sd5, 1'b1, 32'd5000);
      send_poll(16'sd5, 1'b0, 32'd5100);
      // A click released at timestamp zero, across the wrap, stores zero and so
      // leaves no click pending: the later idle request reports nothing.
      send_poll(16'sd5, 1'b1, 32'hFFFF_0000);
      send_poll(16'sd5, 1'b0, 32'hFFFF_0010);
      send_poll(16'sd5, 1'b1, 32'hFFFF_FF00);
      send_poll(16'sd5, 1'b0, 32'd0);
      send_poll(16'sd5, 1'b0, 32'd1000);
      dial     = 16'sd5;
      clock_ms = 32'd1000;

      // Writes to the unused indexes must leave the reset thresholds in place.
      drain_actions();
      write_register(CSR_SPARE_LOW, 16'($urandom_range(0, 65535)));
      write_register(CSR_SPARE_HIGH, 16'($urandom_range(0, 65535)));
      run_gestures(250);

      run_phase(16'd0, 16'd0, 150);
      drain_actions();
      clock_ms = 32'hFFFF_0000;               // Run the largest limits across the wrap.
      run_phase(16'hFFFF, 16'hFFFF, 150);
      run_phase(16'd0, 16'hFFFF, 120);
      run_phase(16'hFFFF, 16'd0, 120);

      // Back-to-back requests and actions with no idling on either side.
      req_burst = 1'b1;
      rsp_burst = 1'b1;
      run_phase(16'd120, 16'd60, 200);
      rsp_burst = 1'b0;

      // The receiver holds off for a long stretch while the sender keeps going.
      drain_actions();
      rsp_hold_request = 1'b1;
      run_phase(HOLD_THRESHOLD_RESET, DOUBLE_WINDOW_RESET, 100);
      req_burst = 1'b0;

      run_phase(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 1000)), 220);
      run_phase(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 1000)), 220);

      drain_actions();
      repeat (10) @(posedge clock);
      if (action_board.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> encoder_button_gesture_classifier_core.f
design/ebgc_pkg.sv
design/ebgc_csr.sv
design/ebgc_classify.sv
design/encoder_button_gesture_classifier_core.sv
test/tb_encoder_button_gesture_classifier_core.sv
